>>> hdl/spct_pkg.sv
// Package for the shape pair collision test: shape kinds, verdict codes,
// field widths and the shape descriptor type. No dependencies.
package spct_pkg;

  localparam int CoordW  = 16;
  localparam int SizeW   = 12;
  localparam int KindW   = 2;
  localparam int VerdW   = 2;
  localparam int DistW   = CoordW;          // magnitude of a coordinate difference
  localparam int SqW     = 2 * DistW;       // square of a distance
  localparam int SumSqW  = SqW + 1;         // sum of two squares

  localparam logic [KindW-1:0] KIND_EMPTY  = 2'd0;
  localparam logic [KindW-1:0] KIND_CIRCLE = 2'd1;
  localparam logic [KindW-1:0] KIND_RECT   = 2'd2;

  localparam logic [VerdW-1:0] VERDICT_NONE  = 2'd0;
  localparam logic [VerdW-1:0] VERDICT_HIT   = 2'd1;
  localparam logic [VerdW-1:0] VERDICT_ERROR = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         radius;
    logic [SizeW-1:0]         width;
    logic [SizeW-1:0]         height;
  } shape_t;

endpackage

>>> hdl/spct_core.sv
// Combinational verdict for one shape pair: circle/circle and
// rectangle/circle tests; other pairs give an error. Depends on spct_pkg.
module spct_core (
  input  spct_pkg::shape_t          shape_a,
  input  spct_pkg::shape_t          shape_b,
  output logic [spct_pkg::VerdW-1:0] verdict
);
  import spct_pkg::*;

  logic signed [CoordW:0] diff_x, diff_y;
  logic [DistW-1:0]       dx, dy;
  logic                   both_circle, both_rect, bad_kind, a_is_circle;
  logic [SizeW-1:0]       rc_radius, rc_width, rc_height;
  logic [SizeW-2:0]       half_w, half_h;
  logic [SizeW:0]         reach_x, reach_y;
  logic [SizeW:0]         radius_sum;
  logic [DistW-1:0]       ex, ey;
  logic [DistW-1:0]       op_x, op_y;
  logic [SizeW:0]         op_r;
  logic [SqW-1:0]         sq_x, sq_y;
  logic [2*(SizeW+1)-1:0] sq_r;
  logic [SumSqW-1:0]      dist_sq;
  logic                   corner_hit;

  // Centre distance is symmetric, so it serves both pair types.
  assign diff_x = {shape_a.x[CoordW-1], shape_a.x} - {shape_b.x[CoordW-1], shape_b.x};
  assign diff_y = {shape_a.y[CoordW-1], shape_a.y} - {shape_b.y[CoordW-1], shape_b.y};
  assign dx = diff_x[CoordW] ? DistW'(-diff_x) : diff_x[DistW-1:0];
  assign dy = diff_y[CoordW] ? DistW'(-diff_y) : diff_y[DistW-1:0];

  assign bad_kind    = (shape_a.kind == KIND_EMPTY) || (shape_b.kind == KIND_EMPTY) ||
                       ((shape_a.kind != KIND_CIRCLE) && (shape_a.kind != KIND_RECT)) ||
                       ((shape_b.kind != KIND_CIRCLE) && (shape_b.kind != KIND_RECT));
  assign both_circle = (shape_a.kind == KIND_CIRCLE) && (shape_b.kind == KIND_CIRCLE);
  assign both_rect   = (shape_a.kind == KIND_RECT) && (shape_b.kind == KIND_RECT);
  assign a_is_circle = (shape_a.kind == KIND_CIRCLE);

  // For a mixed pair, pick the rectangle's sizes and the circle's radius.
  assign rc_radius = a_is_circle ? shape_a.radius : shape_b.radius;
  assign rc_width  = a_is_circle ? shape_b.width  : shape_a.width;
  assign rc_height = a_is_circle ? shape_b.height : shape_a.height;

  assign half_w  = rc_width[SizeW-1:1];
  assign half_h  = rc_height[SizeW-1:1];
  assign reach_x = {2'b00, half_w} + {1'b0, rc_radius};
  assign reach_y = {2'b00, half_h} + {1'b0, rc_radius};
  assign ex      = dx - DistW'(half_w);
  assign ey      = dy - DistW'(half_h);

  assign radius_sum = {1'b0, shape_a.radius} + {1'b0, shape_b.radius};

  // Three squarers shared between the two pair types.
  assign op_x = both_circle ? dx : ex;
  assign op_y = both_circle ? dy : ey;
  assign op_r = both_circle ? radius_sum : {1'b0, rc_radius};

  assign sq_x    = {{DistW{1'b0}}, op_x} * {{DistW{1'b0}}, op_x};
  assign sq_y    = {{DistW{1'b0}}, op_y} * {{DistW{1'b0}}, op_y};
  assign sq_r    = {{(SizeW+1){1'b0}}, op_r} * {{(SizeW+1){1'b0}}, op_r};
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign corner_hit = (dist_sq <= SumSqW'(sq_r));

  always_comb begin
    if (bad_kind || both_rect) begin
      verdict = VERDICT_ERROR;
    end else if (both_circle) begin
      verdict = corner_hit ? VERDICT_HIT : VERDICT_NONE;
    end else if (dx > DistW'(reach_x)) begin
      verdict = VERDICT_NONE;
    end else if (dy > DistW'(reach_y)) begin
      verdict = VERDICT_NONE;
    end else if ((dx <= DistW'(half_w)) || (dy <= DistW'(half_h))) begin
      verdict = VERDICT_HIT;
    end else begin
      verdict = corner_hit ? VERDICT_HIT : VERDICT_NONE;
    end
  end

endmodule

>>> hdl/shape_pair_collision_test_unit.sv
// Top level of the shape pair collision test: stream ports, input and
// result registers around spct_core. Depends on spct_pkg and spct_core.

// Each input word carries two shapes (empty, circle or axis-aligned
// rectangle) and yields exactly one result word with the verdict: 0 no
// collision, 1 collision, 2 error. An empty or undefined kind on either
// side, and a pair of two rectangles, give an error. Two circles collide
// when the squared centre distance is at most the squared sum of the radii;
// a rectangle and a circle are tested with floored half-extents grown by
// the radius, then against the nearest corner. The unit takes one word per
// clock cycle unless a stalled result side holds both registers. A word
// waits in the input register, then the collision logic (two 16-bit and
// one 13-bit squarer, and a compare) lands in the result register. Both
// registers advance together, so a stalled result register still lets the
// input register fill, and the input stalls only when both hold words.
module shape_pair_collision_test_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: a_x[15:0], a_y[31:16], a_radius[43:32],
  // a_width[55:44], a_height[67:56], b_x[83:68], b_y[99:84],
  // b_radius[111:100], b_width[123:112], b_height[135:124].
  input  logic [135:0] in_tdata,
  // Fields from bit 0 up: kind_a[1:0], kind_b[3:2].
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0 up: verdict[1:0], bits 7:2 are zero.
  output logic [7:0]   out_tdata
);
  import spct_pkg::*;

  shape_t            in_shape_a, in_shape_b;
  shape_t            shape_a_r, shape_b_r;
  logic              stage_v_r, stage_v_nxt;
  logic              out_v_r, out_v_nxt;
  logic [VerdW-1:0]  verdict_r, verdict_nxt;
  logic              out_free;
  logic              in_take;

  // Unpack the stream word into the two shape descriptors.
  always_comb begin
    in_shape_a.kind   = in_tuser[1:0];
    in_shape_a.x      = in_tdata[15:0];
    in_shape_a.y      = in_tdata[31:16];
    in_shape_a.radius = in_tdata[43:32];
    in_shape_a.width  = in_tdata[55:44];
    in_shape_a.height = in_tdata[67:56];
    in_shape_b.kind   = in_tuser[3:2];
    in_shape_b.x      = in_tdata[83:68];
    in_shape_b.y      = in_tdata[99:84];
    in_shape_b.radius = in_tdata[111:100];
    in_shape_b.width  = in_tdata[123:112];
    in_shape_b.height = in_tdata[135:124];
  end

  // The result register can load when it is empty or being drained.
  assign out_free  = !out_v_r || out_tready;
  assign in_tready = !stage_v_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  spct_core u_core (
    .shape_a (shape_a_r),
    .shape_b (shape_b_r),
    .verdict (verdict_nxt)
  );

  always_comb begin
    stage_v_nxt = stage_v_r;
    out_v_nxt   = out_v_r;
    if (out_free) begin
      out_v_nxt = stage_v_r;
    end
    if (in_take) begin
      stage_v_nxt = 1'b1;
    end else if (out_free) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      shape_a_r <= in_shape_a;
      shape_b_r <= in_shape_b;
    end
    if (out_free && stage_v_r) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(8-VerdW){1'b0}}, verdict_r};

  // A full pipe with a stalled result must refuse input.
  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input accepted while both registers are held");

  // An empty shape on either side must produce an error verdict.
  a_empty_error : assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && out_free &&
     ((shape_a_r.kind == KIND_EMPTY) || (shape_b_r.kind == KIND_EMPTY)))
    |=> (out_tvalid && (verdict_r == VERDICT_ERROR)))
    else $error("empty shape did not give an error verdict");

  // Two rectangles are not supported and must give an error verdict.
  a_rect_pair_error : assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && out_free &&
     (shape_a_r.kind == KIND_RECT) && (shape_b_r.kind == KIND_RECT))
    |=> (verdict_r == VERDICT_ERROR))
    else $error("rectangle pair did not give an error verdict");

  // A word in the input register moves on whenever the result side is free.
  a_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
    (stage_v_r && out_free) |=> out_v_r)
    else $error("word in the input register was lost");

endmodule

>>> tb/sv/shape_pair_collision_test_unit_tb.sv
// Self-checking testbench for shape_pair_collision_test_unit: directed pairs, then
// random pairs with idle gaps and result stalls. Depends on spct_pkg and the unit.
module shape_pair_collision_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spct_pkg::*;

  // A kind code that the package leaves undefined; the unit must reject it.
  localparam logic [KindW-1:0] KIND_UNDEF = 2'd3;

  localparam int RandomPairs = 950;

  // One row of the directed table. When fixed_verdict is set, the verdict was
  // worked out by hand; otherwise the predictor supplies it.
  typedef struct {
    shape_t           a;
    shape_t           b;
    bit               fixed_verdict;
    logic [VerdW-1:0] verdict;
  } pair_case_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // Fields from bit 0 up: a_x, a_y, a_radius, a_width, a_height,
  // b_x, b_y, b_radius, b_width, b_height.
  logic [135:0] in_tdata = '0;
  // Fields from bit 0 up: kind_a, kind_b.
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // Fields from bit 0 up: verdict, then zero padding.
  logic [7:0]   out_tdata;

  // Verdicts owed by the unit, oldest first.
  logic [VerdW-1:0] pending_verdicts[$];
  int               fault_count = 0;

  // When set, the result side never stalls (a stretch without back-pressure).
  bit rx_steady = 1'b0;
  int stall_left = 0;
  int stall_len;
  logic [VerdW-1:0] owed;

  shape_pair_collision_test_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    else if (pick < 90) return $urandom_range(1, 3);
    else if (pick < 98) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic shape_t mk_shape(logic [KindW-1:0] kind, int x, int y, int radius,
                                      int width, int height);
    shape_t s;
    s.kind   = kind;
    s.x      = 16'(x);
    s.y      = 16'(y);
    s.radius = 12'(radius);
    s.width  = 12'(width);
    s.height = 12'(height);
    return s;
  endfunction

  // Mostly small sizes so that shapes meet often; one in eight spans the full field.
  function automatic logic [SizeW-1:0] random_size();
    if ($urandom_range(0, 7) == 0) return 12'($urandom);
    return 12'($urandom_range(0, 80));
  endfunction

  // Rectangle against circle: reject on the grown half-extents, accept when the
  // centre lies within the rectangle's band on either axis, otherwise compare the
  // distance to the nearest corner with the radius. Halves are floored.
  function automatic logic [VerdW-1:0] rect_circle_verdict(shape_t rect, shape_t circ);
    longint dx, dy, half_w, half_h, rad, ex, ey;
    dx = longint'(circ.x) - longint'(rect.x);
    dy = longint'(circ.y) - longint'(rect.y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    half_w = longint'(rect.width >> 1);
    half_h = longint'(rect.height >> 1);
    rad    = longint'(circ.radius);
    if (dx > half_w + rad) return VERDICT_NONE;
    if (dy > half_h + rad) return VERDICT_NONE;
    if (dx <= half_w) return VERDICT_HIT;
    if (dy <= half_h) return VERDICT_HIT;
    ex = dx - half_w;
    ey = dy - half_h;
    return (ex * ex + ey * ey <= rad * rad) ? VERDICT_HIT : VERDICT_NONE;
  endfunction

  // Verdict for one pair. Sizes that the kind does not use play no part.
  function automatic logic [VerdW-1:0] collision_verdict(shape_t a, shape_t b);
    longint dx, dy, rsum;
    if (a.kind == KIND_EMPTY || b.kind == KIND_EMPTY || a.kind > KIND_RECT ||
        b.kind > KIND_RECT) begin
      return VERDICT_ERROR;
    end
    if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE) begin
      dx   = longint'(a.x) - longint'(b.x);
      dy   = longint'(a.y) - longint'(b.y);
      rsum = longint'(a.radius) + longint'(b.radius);
      return (dx * dx + dy * dy <= rsum * rsum) ? VERDICT_HIT : VERDICT_NONE;
    end
    if (a.kind == KIND_RECT && b.kind == KIND_RECT) return VERDICT_ERROR;
    if (a.kind == KIND_CIRCLE) return rect_circle_verdict(b, a);
    return rect_circle_verdict(a, b);
  endfunction

  // Present one word after an optional idle gap and hold it until the unit
  // takes it. The verdict is queued at the accepting edge.
  task automatic send_pair(input shape_t a, input shape_t b, input logic [VerdW-1:0] want,
                           input bit steady);
    int gap;
    gap = steady ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.height, b.width, b.radius, b.y, b.x, a.height, a.width, a.radius, a.y, a.x};
    in_tuser  <= {b.kind, a.kind};
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(want);
  endtask

  // Result side: random stalls of mixed length, except during steady stretches.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_len = rx_steady ? 0 : idle_cycles();
      if (stall_len == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        stall_left <= stall_len - 1;
      end
    end
  end

  // Every accepted result word must match the oldest owed verdict, padding included.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result word 0x%02h with no verdict pending", out_tdata);
        end
      end else begin
        owed = pending_verdicts.pop_front();
        if (out_tdata !== {6'b0, owed}) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("verdict mismatch: expected %0d, got word 0x%02h", owed, out_tdata);
          end
        end
      end
    end
  end

  initial begin
    pair_case_t       directed_rows[$];
    pair_case_t       row;
    shape_t           a_shape, b_shape;
    logic [VerdW-1:0] want;
    int               idx, pick, reach;
    bit               tx_steady;

    // Directed pairs. Errors, the coincident points and the far-apart extremes are typed in by hand.
    // Empty on either side, and on both.
    directed_rows.push_back('{mk_shape(KIND_EMPTY, 0, 0, 10, 0, 0),
                              mk_shape(KIND_CIRCLE, 0, 0, 10, 0, 0), 1'b1, VERDICT_ERROR});
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 0, 0, 10, 0, 0),
                              mk_shape(KIND_EMPTY, 0, 0, 10, 0, 0), 1'b1, VERDICT_ERROR});
    directed_rows.push_back('{mk_shape(KIND_EMPTY, 5, 5, 0, 0, 0),
                              mk_shape(KIND_EMPTY, 5, 5, 0, 0, 0), 1'b1, VERDICT_ERROR});
    // Undefined kind on either side, even when the shapes overlap.
    directed_rows.push_back('{mk_shape(KIND_UNDEF, 0, 0, 50, 50, 50),
                              mk_shape(KIND_CIRCLE, 0, 0, 50, 0, 0), 1'b1, VERDICT_ERROR});
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 50, 50),
                              mk_shape(KIND_UNDEF, 0, 0, 50, 50, 50), 1'b1, VERDICT_ERROR});
    // Two rectangles are not supported, even when they overlap.
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 100, 100),
                              mk_shape(KIND_RECT, 10, 10, 0, 100, 100), 1'b1, VERDICT_ERROR});
    // Every bit high: undefined kinds with all-ones fields.
    directed_rows.push_back('{mk_shape(KIND_UNDEF, -1, -1, 4095, 4095, 4095),
                              mk_shape(KIND_UNDEF, -1, -1, 4095, 4095, 4095), 1'b1,
                              VERDICT_ERROR});
    // Two points on the same spot touch.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 0, 0, 0, 0, 0),
                              mk_shape(KIND_CIRCLE, 0, 0, 0, 0, 0), 1'b1, VERDICT_HIT});
    // Opposite corners of the coordinate range, largest radii: far apart.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, -32768, -32768, 4095, 0, 0),
                              mk_shape(KIND_CIRCLE, 32767, 32767, 4095, 0, 0), 1'b1,
                              VERDICT_NONE});
    directed_rows.push_back('{mk_shape(KIND_RECT, -32768, 32767, 4095, 4095, 4095),
                              mk_shape(KIND_CIRCLE, 32767, -32768, 4095, 4095, 4095), 1'b1,
                              VERDICT_NONE});
    // Circles exactly touching on a 3-4-5 triangle, then just apart.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 0, 0, 2, 0, 0),
                              mk_shape(KIND_CIRCLE, 3, 4, 3, 0, 0), 1'b0, VERDICT_NONE});
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 0, 0, 2, 0, 0),
                              mk_shape(KIND_CIRCLE, 3, 5, 3, 0, 0), 1'b0, VERDICT_NONE});
    // Largest circles just reaching each other across the full radius sum.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, -4095, 0, 4095, 0, 0),
                              mk_shape(KIND_CIRCLE, 4095, 0, 4095, 0, 0), 1'b0, VERDICT_NONE});
    // A circle's width and height, and a rectangle's radius, must be ignored.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 0, 0, 1, 4095, 4095),
                              mk_shape(KIND_CIRCLE, 100, 0, 1, 4095, 4095), 1'b0,
                              VERDICT_NONE});
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 4095, 10, 10),
                              mk_shape(KIND_CIRCLE, 200, 0, 5, 0, 0), 1'b0, VERDICT_NONE});
    // Odd width floors the half-extent: width 5 misses, width 6 reaches.
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 5, 0),
                              mk_shape(KIND_CIRCLE, 3, 0, 0, 0, 0), 1'b0, VERDICT_NONE});
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 6, 0),
                              mk_shape(KIND_CIRCLE, 3, 0, 0, 0, 0), 1'b0, VERDICT_NONE});
    // Corner test: distance to the corner equals the radius, then exceeds it.
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 4, 4),
                              mk_shape(KIND_CIRCLE, 5, 6, 5, 0, 0), 1'b0, VERDICT_NONE});
    directed_rows.push_back('{mk_shape(KIND_RECT, 0, 0, 0, 4, 4),
                              mk_shape(KIND_CIRCLE, 5, 6, 4, 0, 0), 1'b0, VERDICT_NONE});
    // Same corner case with the circle described first.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, -5, -6, 5, 0, 0),
                              mk_shape(KIND_RECT, 0, 0, 0, 4, 4), 1'b0, VERDICT_NONE});
    // Circle above the rectangle, inside its horizontal band.
    directed_rows.push_back('{mk_shape(KIND_CIRCLE, 1, 30, 10, 0, 0),
                              mk_shape(KIND_RECT, 0, 0, 0, 8, 40), 1'b0, VERDICT_NONE});
    // Largest rectangle and circle overlapping near the top of the range.
    directed_rows.push_back('{mk_shape(KIND_RECT, 32767, 32767, 0, 4095, 4095),
                              mk_shape(KIND_CIRCLE, 28000, 28000, 4095, 0, 0), 1'b0,
                              VERDICT_NONE});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row  = directed_rows[i];
      want = row.fixed_verdict ? row.verdict : collision_verdict(row.a, row.b);
      send_pair(row.a, row.b, want, 1'b0);
    end

    // Hold off the input until the directed verdicts have all come back.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);

    tx_steady = 1'b0;
    for (idx = 0; idx < RandomPairs; idx++) begin
      // Every fifty words, choose afresh whether either side runs without gaps.
      if (idx % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady <= ($urandom_range(0, 3) == 0);
      end
      // Now and then let the pipeline drain completely before going on.
      if (idx % 300 == 150) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
      end

      a_shape.x      = 16'($urandom);
      a_shape.y      = 16'($urandom);
      a_shape.radius = random_size();
      a_shape.width  = random_size();
      a_shape.height = random_size();
      b_shape.radius = random_size();
      b_shape.width  = random_size();
      b_shape.height = random_size();

      // Mostly supported pairs; the rest are arbitrary kinds, errors included.
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        a_shape.kind = KIND_CIRCLE;
        b_shape.kind = KIND_CIRCLE;
      end else if (pick < 65) begin
        a_shape.kind = KIND_RECT;
        b_shape.kind = KIND_CIRCLE;
      end else if (pick < 90) begin
        a_shape.kind = KIND_CIRCLE;
        b_shape.kind = KIND_RECT;
      end else begin
        a_shape.kind = 2'($urandom);
        b_shape.kind = 2'($urandom);
      end

      // Place the second centre within reach of the first so that hits, misses
      // and boundary cases are all common; a tenth lands anywhere.
      reach = (a_shape.kind == KIND_RECT) ?
              int'((a_shape.width > a_shape.height ? a_shape.width : a_shape.height) >> 1) :
              int'(a_shape.radius);
      reach += (b_shape.kind == KIND_RECT) ?
               int'((b_shape.width > b_shape.height ? b_shape.width : b_shape.height) >> 1) :
               int'(b_shape.radius);
      if ($urandom_range(0, 9) == 0) begin
        b_shape.x = 16'($urandom);
        b_shape.y = 16'($urandom);
      end else begin
        b_shape.x = a_shape.x + 16'($urandom_range(0, 2 * reach + 8)) - 16'(reach + 4);
        b_shape.y = a_shape.y + 16'($urandom_range(0, 2 * reach + 8)) - 16'(reach + 4);
      end

      send_pair(a_shape, b_shape, collision_verdict(a_shape, b_shape), tx_steady);
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending_verdicts.size() != 0);
    // Catch any stray word the unit might still emit.
    repeat (10) @(posedge clk);

    if (fault_count == 0) begin
      $display("shape_pair_collision_test_unit_tb: clean");
    end else begin
      $display("shape_pair_collision_test_unit_tb: errors");
    end
    $finish;
  end

  // Watchdog: a time limit far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("shape_pair_collision_test_unit_tb: errors");
    $finish;
  end

endmodule

>>> files.f
hdl/spct_pkg.sv
hdl/spct_core.sv
hdl/shape_pair_collision_test_unit.sv
tb/sv/shape_pair_collision_test_unit_tb.sv
